// ===== rtl/core/gbfs_pkg.sv =====
package gbfs_pkg;

    localparam int GRID_SIDE    = 8;
    localparam int COORD_W      = 3;
    localparam int CELL_W       = 3 * COORD_W;
    localparam int CELLS        = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int MAX_AVOIDERS = 4;
    localparam int SLOT_W       = 2;
    localparam int CNT_W        = 3;
    localparam int DIST_W       = 5;
    localparam int QPTR_W       = CELL_W + 1;

    localparam logic [1:0] REQ_TARGET = 2'd0;
    localparam logic [1:0] REQ_AVOID  = 2'd1;
    localparam logic [1:0] REQ_SOLVE  = 2'd2;

    localparam logic [2:0] DIR_XP = 3'd0;
    localparam logic [2:0] DIR_XN = 3'd1;
    localparam logic [2:0] DIR_YP = 3'd2;
    localparam logic [2:0] DIR_YN = 3'd3;
    localparam logic [2:0] DIR_ZP = 3'd4;
    localparam logic [2:0] DIR_ZN = 3'd5;

    typedef struct packed {
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } cell_t;

    // neighbor in direction d; ok is low when it leaves the grid
    function automatic logic step_ok(input cell_t c, input logic [2:0] d);
        case (d)
            DIR_XP:  step_ok = (c.x != COORD_W'(GRID_SIDE - 1));
            DIR_XN:  step_ok = (c.x != '0);
            DIR_YP:  step_ok = (c.y != COORD_W'(GRID_SIDE - 1));
            DIR_YN:  step_ok = (c.y != '0);
            DIR_ZP:  step_ok = (c.z != COORD_W'(GRID_SIDE - 1));
            DIR_ZN:  step_ok = (c.z != '0);
            default: step_ok = 1'b0;
        endcase
    endfunction

    function automatic cell_t step_cell(input cell_t c, input logic [2:0] d);
        cell_t n;
        n = c;
        case (d)
            DIR_XP:  n.x = c.x + 1'b1;
            DIR_XN:  n.x = c.x - 1'b1;
            DIR_YP:  n.y = c.y + 1'b1;
            DIR_YN:  n.y = c.y - 1'b1;
            DIR_ZP:  n.z = c.z + 1'b1;
            DIR_ZN:  n.z = c.z - 1'b1;
            default: n = c;
        endcase
        step_cell = n;
    endfunction

    function automatic logic [COORD_W-1:0] adiff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
        adiff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/core/gbfs_ram.sv =====
module gbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/grid_bfs_nearest_target_step.sv =====
// Operation: a write is taken in IDLE. A solve clears the visited map, seeds the queue,
//   then for each dequeued cell does a queue read, a map read, six direction checks with
//   a neighbor read for each direction tried, and a closing check. A target cell ends the
//   search and its first step is read out (the fallback answers if it is the start); an
//   empty queue also runs the fallback. Requests are taken one at a time.
// Reset: rst_n is asynchronous, active low. It starts a clearing pass over the target map,
//   during which no request is accepted.
module grid_bfs_nearest_target_step
    import gbfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] pos_z,
    input  logic [SLOT_W-1:0]  ghost_slot,
    input  logic               target_present,
    input  logic [2:0]         heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         next_dir,
    output logic               by_search
);

    typedef enum logic [10:0] {
        ST_INIT  = 11'b00000000001, // clear target map after reset
        ST_IDLE  = 11'b00000000010,
        ST_CLR   = 11'b00000000100, // clear visited map
        ST_SEED  = 11'b00000001000, // push start cell
        ST_DEQ   = 11'b00000010000, // read queue head
        ST_DEQW  = 11'b00000100000, // queue data back; read target map / first step
        ST_CHK   = 11'b00001000000, // target test, then per-direction issue
        ST_NRD   = 11'b00010000000, // neighbor visited read returns
        ST_FIND  = 11'b00100000000, // read first step of found cell
        ST_FALL  = 11'b01000000000, // fallback scoring, one direction per cycle
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  gcount_reg;
    cell_t             av_reg [MAX_AVOIDERS];
    cell_t             start_reg;
    logic [2:0]        head_reg;
    logic [CELL_W-1:0] clr_reg;
    logic [QPTR_W-1:0] qh_reg, qt_reg;
    cell_t             cur_reg;
    logic [2:0]        cur_fs_reg;
    logic [2:0]        d_reg;
    cell_t             nb_reg;
    logic [6:0]        best_reg;   // bit 6 = no score yet
    logic [2:0]        bdir_reg;
    logic [2:0]        res_dir_reg;
    logic              res_src_reg;
    logic              valid_out_reg;

    // memories
    logic              tm_we, tm_wd, tm_rd;
    logic [CELL_W-1:0] tm_wa, tm_ra;
    logic              vm_we, vm_wd, vm_rd;
    logic [CELL_W-1:0] vm_wa, vm_ra;
    logic              fs_we;
    logic [2:0]        fs_wd, fs_rd;
    logic [CELL_W-1:0] fs_wa, fs_ra;
    logic              q_we;
    logic [CELL_W-1:0] q_wd, q_rd, q_wa, q_ra;

    gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_target (.clk(clk), .we(tm_we), .waddr(tm_wa),
        .wdata(tm_wd), .raddr(tm_ra), .rdata(tm_rd));
    gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visit (.clk(clk), .we(vm_we), .waddr(vm_wa),
        .wdata(vm_wd), .raddr(vm_ra), .rdata(vm_rd));
    gbfs_ram #(.WIDTH(3), .DEPTH(CELLS)) u_first (.clk(clk), .we(fs_we), .waddr(fs_wa),
        .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));
    gbfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_queue (.clk(clk), .we(q_we), .waddr(q_wa),
        .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

    logic [CNT_W-1:0] active;
    assign active = (gcount_reg > CNT_W'(MAX_AVOIDERS)) ? CNT_W'(MAX_AVOIDERS) : gcount_reg;

    logic [2:0] rev;
    logic       rev_ok;
    assign rev_ok = (head_reg <= DIR_ZN);
    assign rev    = head_reg ^ 3'd1;

    // blocked test: within Manhattan distance 1 of an active avoider, never the start
    function automatic logic near1(input cell_t a, input cell_t c);
        logic [DIST_W-1:0] s;
        s = DIST_W'(adiff(a.x, c.x)) + DIST_W'(adiff(a.y, c.y)) + DIST_W'(adiff(a.z, c.z));
        near1 = (s <= DIST_W'(1));
    endfunction

    logic blk_nb;
    always_comb
    begin
        blk_nb = 1'b0;
        for (int a = 0; a < MAX_AVOIDERS; a++)
        begin
            if (CNT_W'(a) < active && near1(av_reg[a], nb_reg))
            begin
                blk_nb = 1'b1;
            end
        end
        if (nb_reg == start_reg)
        begin
            blk_nb = 1'b0;
        end
    end

    // fallback score of the candidate step
    logic [DIST_W-1:0] near_d;
    always_comb
    begin
        logic [DIST_W-1:0] s;
        near_d = '1;
        for (int a = 0; a < MAX_AVOIDERS; a++)
        begin
            s = DIST_W'(adiff(av_reg[a].x, nb_reg.x)) + DIST_W'(adiff(av_reg[a].y, nb_reg.y))
                + DIST_W'(adiff(av_reg[a].z, nb_reg.z));
            if (CNT_W'(a) < active && s < near_d)
            begin
                near_d = s;
            end
        end
    end
    logic [6:0] score;
    assign score = (active == '0) ? 7'h3f : {2'b00, near_d};

    logic cur_is_start;
    assign cur_is_start = (cur_reg == start_reg);

    logic dir_try;  // current direction may expand
    assign dir_try = step_ok(cur_reg, d_reg) && !(cur_is_start && rev_ok && d_reg == rev);

    logic fall_try;
    logic fall_ok;
    assign fall_try = step_ok(start_reg, d_reg) && !(rev_ok && d_reg == rev);
    assign fall_ok  = fall_try && !blk_nb;

    assign in_ready  = (state_reg == ST_IDLE) && !valid_out_reg;
    assign out_valid = valid_out_reg;
    assign next_dir  = res_dir_reg;
    assign by_search = res_src_reg;

    logic acc;
    assign acc = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        tm_we = 1'b0; tm_wa = clr_reg; tm_wd = 1'b0; tm_ra = cur_reg;
        vm_we = 1'b0; vm_wa = clr_reg; vm_wd = 1'b0; vm_ra = nb_reg;
        fs_we = 1'b0; fs_wa = nb_reg; fs_wd = cur_is_start ? d_reg : cur_fs_reg;
        fs_ra = cur_reg;
        q_we = 1'b0; q_wa = qt_reg[CELL_W-1:0]; q_wd = nb_reg; q_ra = qh_reg[CELL_W-1:0];
        case (state_reg)
            ST_INIT:
            begin
                tm_we = 1'b1;
                if (clr_reg == CELL_W'(CELLS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                tm_wa = {pos_z, pos_y, pos_x};
                tm_wd = target_present;
                if (acc && req_type == REQ_TARGET) tm_we = 1'b1;
                if (acc && req_type == REQ_SOLVE) state_next = ST_CLR;
            end
            ST_CLR:
            begin
                vm_we = 1'b1;
                if (clr_reg == CELL_W'(CELLS - 1)) state_next = ST_SEED;
            end
            ST_SEED:
            begin
                vm_we = 1'b1; vm_wa = start_reg; vm_wd = 1'b1;
                q_we = 1'b1; q_wa = '0; q_wd = start_reg;
                state_next = ST_DEQ;
            end
            ST_DEQ:
            begin
                if (qh_reg == qt_reg) state_next = ST_FALL;
                else state_next = ST_DEQW;
            end
            ST_DEQW:
            begin
                tm_ra = q_rd; fs_ra = q_rd;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (d_reg == 3'd0 && tm_rd)
                begin
                    state_next = cur_is_start ? ST_FALL : ST_FIND;
                end
                else if (d_reg == 3'd6)
                begin
                    state_next = ST_DEQ;
                end
                else if (dir_try)
                begin
                    vm_ra = step_cell(cur_reg, d_reg);
                    state_next = ST_NRD;
                end
            end
            ST_NRD:
            begin
                if (!vm_rd && !blk_nb)
                begin
                    vm_we = 1'b1; vm_wa = nb_reg; vm_wd = 1'b1;
                    fs_we = 1'b1;
                    q_we = !qt_reg[CELL_W];
                end
                state_next = ST_CHK;
            end
            ST_FIND: state_next = ST_OUT;
            ST_FALL:
            begin
                if (d_reg == 3'd6) state_next = ST_OUT;
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_reg       <= '0;
            gcount_reg    <= CNT_W'(4);
            valid_out_reg <= 1'b0;
            for (int i = 0; i < MAX_AVOIDERS; i++)
            begin
                av_reg[i].x <= (i % 4 == 1 || i % 4 == 3) ? COORD_W'(GRID_SIDE - 1) : '0;
                av_reg[i].y <= (i % 4 >= 2) ? COORD_W'(GRID_SIDE - 1) : '0;
                av_reg[i].z <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) gcount_reg <= cfg_wdata;
            if (valid_out_reg && out_ready) valid_out_reg <= 1'b0;
            case (state_reg)
                ST_INIT, ST_CLR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE:
                begin
                    clr_reg <= '0;
                    if (acc && req_type == REQ_AVOID)
                    begin
                        av_reg[ghost_slot] <= '{z: pos_z, y: pos_y, x: pos_x};
                    end
                    if (acc && req_type == REQ_SOLVE)
                    begin
                        start_reg <= '{z: pos_z, y: pos_y, x: pos_x};
                        head_reg  <= heading;
                    end
                end
                ST_SEED:
                begin
                    qh_reg <= '0; qt_reg <= QPTR_W'(1);
                end
                ST_DEQ:
                begin
                    qh_reg <= qh_reg + 1'b1;
                    d_reg  <= '0;
                    best_reg <= 7'h40; bdir_reg <= rev_ok ? head_reg : DIR_XP;
                    nb_reg <= step_cell(start_reg, DIR_XP);
                end
                ST_DEQW: cur_reg <= q_rd;
                ST_CHK:
                begin
                    if (d_reg == 3'd0)
                    begin
                        cur_fs_reg <= fs_rd;
                    end
                    if (d_reg == 3'd0 && tm_rd)
                    begin
                        d_reg <= '0;
                        best_reg <= 7'h40; bdir_reg <= rev_ok ? head_reg : DIR_XP;
                        nb_reg <= step_cell(start_reg, DIR_XP);
                    end
                    else if (d_reg != 3'd6)
                    begin
                        nb_reg <= step_cell(cur_reg, d_reg);
                        if (!dir_try) d_reg <= d_reg + 1'b1;
                    end
                end
                ST_NRD:
                begin
                    if (!vm_rd && !blk_nb && !qt_reg[CELL_W]) qt_reg <= qt_reg + 1'b1;
                    d_reg <= d_reg + 1'b1;
                end
                ST_FIND:
                begin
                    res_dir_reg <= fs_rd; res_src_reg <= 1'b1;
                end
                ST_FALL:
                begin
                    if (d_reg != 3'd6)
                    begin
                        if (fall_ok && (best_reg[6] || score > best_reg))
                        begin
                            best_reg <= score; bdir_reg <= d_reg;
                        end
                        d_reg  <= d_reg + 1'b1;
                        nb_reg <= step_cell(start_reg, d_reg + 1'b1);
                    end
                    else
                    begin
                        res_dir_reg <= bdir_reg; res_src_reg <= 1'b0;
                    end
                end
                ST_OUT: valid_out_reg <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule
